### hw/rtl/siw_pkg.sv
// ============================================================================
// siw_pkg
// Shared constants and a helper function for the signed index wrap block.
// ============================================================================
package siw_pkg;

    localparam int unsigned REG_WRAP_RANGE = 0;
    localparam int unsigned RANGE_RESET    = 1;

    // byte offset bits of one register slot: 4-byte slots up to 32 bits, else 8
    function automatic int unsigned reg_addr_lsb(input int unsigned width);
        int unsigned lsb;
        lsb = (width > 32) ? 3 : 2;
        return lsb;
    endfunction

endpackage

### hw/rtl/siw_cfg.sv
// ============================================================================
// siw_cfg
// APB register file holding wrap_range; writes of zero are dropped.
// ============================================================================
module siw_cfg #(
    parameter int INDEX_WIDTH = 32,
    parameter int DATA_W      = 32,
    parameter int ADDR_LSB    = 2,
    parameter int PADDR_W     = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output logic [INDEX_WIDTH-1:0] wrap_range
);
    import siw_pkg::*;

    logic [INDEX_WIDTH-1:0] range_reg;
    logic [INDEX_WIDTH-1:0] range_next;
    logic [INDEX_WIDTH-1:0] wdata;
    logic                   sel_range;

    assign pready    = 1'b1;
    assign wdata     = pwdata[INDEX_WIDTH-1:0];
    assign sel_range = (paddr[PADDR_W-1:ADDR_LSB] == (PADDR_W-ADDR_LSB)'(REG_WRAP_RANGE));

    always_comb
    begin
        range_next = range_reg;
        if (psel && penable && pwrite && pready && sel_range && (wdata != '0))
        begin
            range_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= INDEX_WIDTH'(RANGE_RESET);
        end
        else
        begin
            range_reg <= range_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_range)
        begin
            prdata = DATA_W'(range_reg);
        end
    end

    assign wrap_range = range_reg;

endmodule

### hw/rtl/siw_prep.sv
// ============================================================================
// siw_prep
// Entry stage: splits the signed index into sign and magnitude.
// ============================================================================
module siw_prep #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [INDEX_WIDTH-1:0] index,
    output logic                   valid,
    output logic                   neg,
    output logic [INDEX_WIDTH-1:0] mag
);
    logic                   valid_reg;
    logic                   neg_reg;
    logic [INDEX_WIDTH-1:0] mag_reg;
    logic                   neg_next;
    logic [INDEX_WIDTH-1:0] mag_next;

    assign neg_next = index[INDEX_WIDTH-1];
    assign mag_next = neg_next ? (~index + INDEX_WIDTH'(1)) : index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    assign valid = valid_reg;
    assign neg   = neg_reg;
    assign mag   = mag_reg;

endmodule

### hw/rtl/siw_div_stage.sv
// ============================================================================
// siw_div_stage
// One restoring-division step: shifts in a dividend bit, subtracts if it fits.
// ============================================================================
module siw_div_stage #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [INDEX_WIDTH-1:0] range,
    input  logic                   valid_in,
    input  logic                   neg_in,
    input  logic [INDEX_WIDTH-1:0] rem_in,
    input  logic [INDEX_WIDTH-1:0] dvd_in,
    output logic                   valid_out,
    output logic                   neg_out,
    output logic [INDEX_WIDTH-1:0] rem_out,
    output logic [INDEX_WIDTH-1:0] dvd_out
);
    logic                   valid_reg;
    logic                   neg_reg;
    logic [INDEX_WIDTH-1:0] rem_reg;
    logic [INDEX_WIDTH-1:0] dvd_reg;
    logic [INDEX_WIDTH:0]   trial;
    logic [INDEX_WIDTH:0]   diff;
    logic [INDEX_WIDTH-1:0] rem_next;

    assign trial = {rem_in, dvd_in[INDEX_WIDTH-1]};
    assign diff  = trial - {1'b0, range};

    always_comb
    begin
        if (trial >= {1'b0, range})
        begin
            rem_next = diff[INDEX_WIDTH-1:0];
        end
        else
        begin
            rem_next = trial[INDEX_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= neg_in;
            rem_reg <= rem_next;
            dvd_reg <= {dvd_in[INDEX_WIDTH-2:0], 1'b0};
        end
    end

    assign valid_out = valid_reg;
    assign neg_out   = neg_reg;
    assign rem_out   = rem_reg;
    assign dvd_out   = dvd_reg;

endmodule

### hw/rtl/siw_fix.sv
// ============================================================================
// siw_fix
// Output stage: folds a negative remainder back into range, holds the result.
// ============================================================================
module siw_fix #(
    parameter int INDEX_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [INDEX_WIDTH-1:0] range,
    input  logic                   valid_in,
    input  logic                   neg_in,
    input  logic [INDEX_WIDTH-1:0] rem_in,
    output logic                   valid_out,
    output logic [INDEX_WIDTH-1:0] result
);
    logic                   valid_reg;
    logic [INDEX_WIDTH-1:0] result_reg;
    logic [INDEX_WIDTH-1:0] result_next;

    always_comb
    begin
        if (neg_in && (rem_in != '0))
        begin
            result_next = range - rem_in;
        end
        else
        begin
            result_next = rem_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign valid_out = valid_reg;
    assign result    = result_reg;

endmodule

### hw/rtl/signed_index_wrap_top.sv
// ============================================================================
// signed_index_wrap_top
// Floored modulo of a signed index by the programmed wrap range.
// ----------------------------------------------------------------------------
// Input channel: raw_index with in_valid / in_stall. Output channel:
// ring_index with out_valid / out_stall. A transaction completes on a
// rising edge with valid high and stall low.
// wrap_range sits at APB offset 0; writes of zero are dropped, reads return
// the current value. Program it only while no transaction is in flight.
// The pipeline has one sign / magnitude stage, one restoring-division
// stage per index bit and one correction and output stage. A new
// transaction is taken every cycle while in_stall is low.
// When the receiver stalls with a result waiting, the whole pipeline
// freezes and in_stall rises in the same cycle; nothing is dropped or
// repeated. Reset empties the pipeline and sets wrap_range to 1.
// ============================================================================
module signed_index_wrap_top #(
    parameter int INDEX_WIDTH = 32,
    localparam int DATA_W   = (INDEX_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB = siw_pkg::reg_addr_lsb(INDEX_WIDTH),
    localparam int PADDR_W  = ADDR_LSB + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [INDEX_WIDTH-1:0] raw_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [INDEX_WIDTH-1:0] ring_index
);
    import siw_pkg::*;

    logic                   en;
    logic [INDEX_WIDTH-1:0] wrap_range;

    logic                   valid_s [INDEX_WIDTH+1];
    logic                   neg_s   [INDEX_WIDTH+1];
    logic [INDEX_WIDTH-1:0] rem_s   [INDEX_WIDTH+1];
    logic [INDEX_WIDTH-1:0] dvd_s   [INDEX_WIDTH+1];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;
    assign rem_s[0] = '0;

    siw_cfg #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .DATA_W      (DATA_W),
        .ADDR_LSB    (ADDR_LSB),
        .PADDR_W     (PADDR_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .wrap_range (wrap_range)
    );

    siw_prep #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .index    (raw_index),
        .valid    (valid_s[0]),
        .neg      (neg_s[0]),
        .mag      (dvd_s[0])
    );

    for (genvar i = 0; i < INDEX_WIDTH; i++)
    begin : g_div
        siw_div_stage #(
            .INDEX_WIDTH (INDEX_WIDTH)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .range     (wrap_range),
            .valid_in  (valid_s[i]),
            .neg_in    (neg_s[i]),
            .rem_in    (rem_s[i]),
            .dvd_in    (dvd_s[i]),
            .valid_out (valid_s[i+1]),
            .neg_out   (neg_s[i+1]),
            .rem_out   (rem_s[i+1]),
            .dvd_out   (dvd_s[i+1])
        );
    end

    siw_fix #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .range     (wrap_range),
        .valid_in  (valid_s[INDEX_WIDTH]),
        .neg_in    (neg_s[INDEX_WIDTH]),
        .rem_in    (rem_s[INDEX_WIDTH]),
        .valid_out (out_valid),
        .result    (ring_index)
    );

endmodule
